@@ rtl/ripc_pkg.sv @@
// Package for the rand index pair counter: beat types and shared constants.
// No dependencies; the other files in rtl/ but ripc_scan refer to it by scoped names.
`default_nettype none

package ripc_pkg;

  // Fixed field widths of the input and result beats
  localparam int IN_LABEL_W = 6;
  localparam int CNT_OUT_W  = 21;
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_W     = FRAC_BITS + 1;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_ITEMS  = 1024;
  localparam int DEF_LABEL_BITS = 6;

  // One input beat
  typedef struct packed {
    logic [IN_LABEL_W-1:0] first_label;
    logic [IN_LABEL_W-1:0] second_label;
    logic                  is_last;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic [CNT_OUT_W-1:0] agree_both;
    logic [CNT_OUT_W-1:0] agree_first_only;
    logic [CNT_OUT_W-1:0] agree_second_only;
    logic [CNT_OUT_W-1:0] agree_neither;
    logic [FRAC_W-1:0]    rand_fraction;
    logic                 overflow;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/ripc_scan.sv @@
// Label store and pair scan: holds the stored label pairs in a one-port-read
// synchronous memory and walks it once per new item. Uses ripc_pkg only via the top.
`default_nettype none

module ripc_scan #(
  parameter int MAX_ITEMS  = 1024,
  parameter int LABEL_BITS = 6,
  parameter int NW         = $clog2(MAX_ITEMS + 1),
  parameter int CW         = 2 * NW
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  go,
  input  wire logic [LABEL_BITS-1:0] first,
  input  wire logic [LABEL_BITS-1:0] second,
  input  wire logic                  clr,
  output logic                       done,
  output logic [NW-1:0]              count,
  output logic [CW-1:0]              both,
  output logic [CW-1:0]              only_first,
  output logic [CW-1:0]              only_second,
  output logic [CW-1:0]              neither,
  output logic                       overflow
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int EW = 2 * LABEL_BITS;
  localparam logic [NW-1:0] MAX_CNT = NW'(MAX_ITEMS);

  logic [EW-1:0]         mem [MAX_ITEMS];
  logic [EW-1:0]         rd_data;
  logic [NW-1:0]         rd_ptr;
  logic                  active;
  logic                  pend;
  logic [LABEL_BITS-1:0] cur_f;
  logic [LABEL_BITS-1:0] cur_s;
  logic                  issuing;
  logic                  finish;
  logic                  same_f;
  logic                  same_s;

  assign issuing = active && (rd_ptr != count);
  assign finish  = active && !issuing && !pend;
  assign same_f  = (rd_data[LABEL_BITS-1:0] == cur_f);
  assign same_s  = (rd_data[EW-1:LABEL_BITS] == cur_s);

  // Store the new pair at the fill point; reads stay below it
  always_ff @(posedge clk) begin
    if (go && (count != MAX_CNT)) begin
      mem[count[AW-1:0]] <= {second, first};
    end
    if (issuing) begin
      rd_data <= mem[rd_ptr[AW-1:0]];
    end
  end

  // Walk the stored entries and class each pair against the new item
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pend        <= 1'b0;
      done        <= 1'b0;
      count       <= '0;
      both        <= '0;
      only_first  <= '0;
      only_second <= '0;
      neither     <= '0;
      overflow    <= 1'b0;
      rd_ptr      <= '0;
    end else begin
      done <= 1'b0;
      pend <= issuing;
      if (clr) begin
        count       <= '0;
        both        <= '0;
        only_first  <= '0;
        only_second <= '0;
        neither     <= '0;
        overflow    <= 1'b0;
      end else if (go) begin
        if (count != MAX_CNT) begin
          active <= 1'b1;
          rd_ptr <= '0;
          cur_f  <= first;
          cur_s  <= second;
        end else begin
          overflow <= 1'b1;
          done     <= 1'b1;
        end
      end else begin
        if (issuing) begin
          rd_ptr <= rd_ptr + NW'(1);
        end
        // Each stored pair counts twice: (i,j) and (j,i)
        if (pend) begin
          if (same_f && same_s) begin
            both <= both + CW'(2);
          end else if (same_f) begin
            only_first <= only_first + CW'(2);
          end else if (same_s) begin
            only_second <= only_second + CW'(2);
          end else begin
            neither <= neither + CW'(2);
          end
        end
        // Self pair counts once, then the item joins the set
        if (finish) begin
          both   <= both + CW'(1);
          count  <= count + NW'(1);
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ripc_div.sv @@
// Restoring divider: one quotient bit per cycle, FRAC_W bits of num*2^16/den.
// Depends on ripc_pkg for the fraction width.
`default_nettype none

module ripc_div #(
  parameter int W = 22
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [W-1:0]                num,
  input  wire logic [W-1:0]                den,
  output logic                             done,
  output logic [ripc_pkg::FRAC_W-1:0]      quot
);

  localparam int FRAC_W = ripc_pkg::FRAC_W;
  localparam int STEP_W = $clog2(FRAC_W);

  logic [W:0]          rem;
  logic [W-1:0]        den_r;
  logic [FRAC_W-1:0]   q;
  logic [STEP_W-1:0]   step;
  logic                run;
  logic                zero;
  logic [W+1:0]        diff;
  logic                ge;
  logic [W-1:0]        new_rem;

  // Trial subtract of the divisor; a negative result keeps the old remainder
  assign diff    = {1'b0, rem} - {2'b00, den_r};
  assign ge      = !diff[W+1];
  assign new_rem = ge ? diff[W-1:0] : rem[W-1:0];
  assign quot    = zero ? '0 : q;

  // Shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        rem   <= {1'b0, num};
        den_r <= den;
        zero  <= (den == '0);
        step  <= STEP_W'(FRAC_W - 1);
      end else if (run) begin
        q   <= {q[FRAC_W-2:0], ge};
        rem <= {new_rem, 1'b0};
        if (step == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - STEP_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/rand_index_pair_counter_core.sv @@
// Rand index pair counter top level: handshake, sequencing, final square and divide.
// Depends on ripc_pkg, ripc_scan and ripc_div.
//
// Each accepted item is compared with every item stored before it, one stored
// entry per cycle through the single read port of the label memory, and busy
// stays high until that walk is done. An item beyond capacity keeps busy high
// for one cycle. An item marked last also goes through the square of the item
// count and the bit-serial divide (17 quotient steps plus launch and hand-off),
// after which the result shows for exactly one cycle on result with done high;
// it cannot be held off. busy is already low in that cycle, so the next item
// may be started at once; the counts have been cleared for it.
`default_nettype none

module rand_index_pair_counter_core #(
  parameter int MAX_ITEMS  = ripc_pkg::DEF_MAX_ITEMS,
  parameter int LABEL_BITS = ripc_pkg::DEF_LABEL_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire ripc_pkg::in_item_t  item,
  output logic                     done,
  output ripc_pkg::out_item_t      result
);

  localparam int NW        = $clog2(MAX_ITEMS + 1);
  localparam int CW        = 2 * NW;
  localparam int CNT_OUT_W = ripc_pkg::CNT_OUT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SQUARE,
    S_DIV
  } state_t;

  state_t                     state;
  logic                       last_r;
  logic                       div_start;
  logic [CW-1:0]              total;
  logic                       go;
  logic                       clr;
  logic                       scan_done;
  logic [NW-1:0]              count;
  logic [CW-1:0]              both;
  logic [CW-1:0]              only_first;
  logic [CW-1:0]              only_second;
  logic [CW-1:0]              neither;
  logic                       overflow;
  logic [CW:0]                agree_sum;
  logic                       div_done;
  logic [ripc_pkg::FRAC_W-1:0] quot;

  assign busy      = (state != S_IDLE);
  assign go        = start && !busy;
  assign clr       = (state == S_DIV) && div_done;
  assign agree_sum = {1'b0, both} + {1'b0, neither};

  ripc_scan #(
    .MAX_ITEMS  (MAX_ITEMS),
    .LABEL_BITS (LABEL_BITS),
    .NW         (NW),
    .CW         (CW)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .first       (LABEL_BITS'(item.first_label)),
    .second      (LABEL_BITS'(item.second_label)),
    .clr         (clr),
    .done        (scan_done),
    .count       (count),
    .both        (both),
    .only_first  (only_first),
    .only_second (only_second),
    .neither     (neither),
    .overflow    (overflow)
  );

  ripc_div #(
    .W (CW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (agree_sum[CW-1:0]),
    .den   (total),
    .done  (div_done),
    .quot  (quot)
  );

  // Sequence scan, square, divide; drive the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            last_r <= item.is_last;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= last_r ? S_SQUARE : S_IDLE;
          end
        end
        S_SQUARE: begin
          total     <= CW'(count) * CW'(count);
          div_start <= 1'b1;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            result.agree_both        <= CNT_OUT_W'(both);
            result.agree_first_only  <= CNT_OUT_W'(only_first);
            result.agree_second_only <= CNT_OUT_W'(only_second);
            result.agree_neither     <= CNT_OUT_W'(neither);
            result.rand_fraction     <= quot;
            result.overflow          <= overflow;
            done                     <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ripc_check.sv @@
// Port-level checker for rand_index_pair_counter_core, bound to the top level.
// Depends on ripc_pkg for the result beat type.
`default_nettype none

module ripc_check (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire ripc_pkg::out_item_t result
);

  // An accepted beat always starts a busy period
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted beat");

  // A result beat only follows a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without preceding work");

  // A result beat lasts exactly one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  // The block is idle again while the result shows
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy high during result beat");

  // The index never exceeds one
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.rand_fraction <= 17'h10000))
    else $error("rand fraction above one");

endmodule

bind rand_index_pair_counter_core ripc_check u_ripc_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

@@ dv/tb_rand_index_pair_counter_core.sv @@
// Self-checking testbench for rand_index_pair_counter_core. Labeled beats are
// scored by a local pair-counting model or typed in by hand, and compared with every result.
// Depends on ripc_pkg and the RTL in rtl/.
`default_nettype none

module tb_rand_index_pair_counter_core;

  localparam int CAPACITY      = ripc_pkg::DEF_MAX_ITEMS;
  localparam int LBITS         = ripc_pkg::DEF_LABEL_BITS;
  localparam int RANDOM_ITEMS  = 580;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 3;
  localparam int IDLE_PCT [PHASES] = '{36, 56, 0};

  // One directed beat; want holds the result where it is typed in by hand
  typedef struct packed {
    ripc_pkg::in_item_t  beat;
    logic                typed;
    ripc_pkg::out_item_t want;
  } step_row_t;

  localparam int DIRECTED_LEN = 17;
  localparam step_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // single-item sets, right after reset, label extremes
    '{'{6'd63, 6'd0,  1'b1}, 1'b1, '{21'd1, 21'd0, 21'd0, 21'd0, 17'd65536, 1'b0}},
    '{'{6'd0,  6'd63, 1'b1}, 1'b1, '{21'd1, 21'd0, 21'd0, 21'd0, 17'd65536, 1'b0}},
    // two items agreeing in both labelings
    '{'{6'd5,  6'd9,  1'b0}, 1'b0, '0},
    '{'{6'd5,  6'd9,  1'b1}, 1'b1, '{21'd4, 21'd0, 21'd0, 21'd0, 17'd65536, 1'b0}},
    // two items differing in both
    '{'{6'd0,  6'd0,  1'b0}, 1'b0, '0},
    '{'{6'd63, 6'd63, 1'b1}, 1'b1, '{21'd2, 21'd0, 21'd0, 21'd2, 17'd65536, 1'b0}},
    // agree in the first labeling only
    '{'{6'd10, 6'd1,  1'b0}, 1'b0, '0},
    '{'{6'd10, 6'd2,  1'b1}, 1'b1, '{21'd2, 21'd2, 21'd0, 21'd0, 17'd32768, 1'b0}},
    // agree in the second labeling only
    '{'{6'd1,  6'd7,  1'b0}, 1'b0, '0},
    '{'{6'd2,  6'd7,  1'b1}, 1'b1, '{21'd2, 21'd0, 21'd2, 21'd0, 17'd32768, 1'b0}},
    // alternating bit patterns, all four classes in one set
    '{'{6'd42, 6'd21, 1'b0}, 1'b0, '0},
    '{'{6'd21, 6'd42, 1'b0}, 1'b0, '0},
    '{'{6'd42, 6'd42, 1'b0}, 1'b0, '0},
    '{'{6'd21, 6'd21, 1'b1}, 1'b0, '0},
    // uneven fraction
    '{'{6'd0,  6'd0,  1'b0}, 1'b0, '0},
    '{'{6'd0,  6'd1,  1'b0}, 1'b0, '0},
    '{'{6'd1,  6'd1,  1'b1}, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic                done;
  ripc_pkg::in_item_t  item;
  ripc_pkg::out_item_t result;

  int                  idle_pct;
  int                  mismatch_count = 0;
  ripc_pkg::out_item_t awaited_scores [$];

  // Pair-counting model state
  logic [2*LBITS-1:0] label_pairs [CAPACITY];
  int unsigned        pairs_stored;
  longint unsigned    tally_both, tally_first, tally_second, tally_neither;
  bit                 dropped_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rand_index_pair_counter_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  function automatic void clear_tallies();
    pairs_stored  = 0;
    tally_both    = 0;
    tally_first   = 0;
    tally_second  = 0;
    tally_neither = 0;
    dropped_seen  = 1'b0;
  endfunction

  // Class the new item against every stored one; return 1 with the score on a last beat
  function automatic bit score_beat(input ripc_pkg::in_item_t b,
                                    output ripc_pkg::out_item_t score);
    logic [LBITS-1:0] f, s;
    bit               same_f, same_s;
    longint unsigned  total, frac;
    f = b.first_label[LBITS-1:0];
    s = b.second_label[LBITS-1:0];
    score = '0;
    if (pairs_stored < CAPACITY) begin
      for (int unsigned j = 0; j < pairs_stored; j++) begin
        same_f = label_pairs[j][LBITS-1:0] == f;
        same_s = label_pairs[j][2*LBITS-1:LBITS] == s;
        if (same_f && same_s) tally_both += 2;
        else if (same_f) tally_first += 2;
        else if (same_s) tally_second += 2;
        else tally_neither += 2;
      end
      tally_both += 1;
      label_pairs[pairs_stored] = {s, f};
      pairs_stored++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (!b.is_last) return 1'b0;
    total = longint'(pairs_stored) * longint'(pairs_stored);
    frac  = (total == 0) ? 0 :
            ((tally_both + tally_neither) << ripc_pkg::FRAC_BITS) / total;
    score.agree_both        = tally_both[ripc_pkg::CNT_OUT_W-1:0];
    score.agree_first_only  = tally_first[ripc_pkg::CNT_OUT_W-1:0];
    score.agree_second_only = tally_second[ripc_pkg::CNT_OUT_W-1:0];
    score.agree_neither     = tally_neither[ripc_pkg::CNT_OUT_W-1:0];
    score.rand_fraction     = frac[ripc_pkg::FRAC_W-1:0];
    score.overflow          = dropped_seen;
    clear_tallies();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Drive one beat, hold it until accepted, then idle at random
  task automatic send_beat(input ripc_pkg::in_item_t b, input bit typed,
                           input ripc_pkg::out_item_t want);
    ripc_pkg::out_item_t score;
    start <= 1'b1;
    item  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (score_beat(b, score)) awaited_scores.push_back(typed ? want : score);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every pending score has come back
  task automatic drain_scores();
    start <= 1'b0;
    do @(posedge clk); while (awaited_scores.size() != 0);
  endtask

  // One set of random labels; a small alphabet makes agreements common
  task automatic send_random_set(input int unsigned set_len);
    ripc_pkg::in_item_t b;
    int unsigned        alphabet;
    alphabet = ($urandom_range(2) == 0) ? 63 : $urandom_range(3, 1);
    for (int unsigned k = 0; k < set_len; k++) begin
      b.first_label  = ripc_pkg::IN_LABEL_W'($urandom_range(alphabet));
      b.second_label = ripc_pkg::IN_LABEL_W'($urandom_range(alphabet));
      b.is_last      = (k == set_len - 1);
      send_beat(b, 1'b0, '0);
    end
  endtask

  // Check each result beat against the oldest pending score
  always @(posedge clk) begin
    ripc_pkg::out_item_t want;
    if (done) begin
      if (awaited_scores.size() == 0) begin
        report_mismatch("result with none pending", 0, 0);
      end else begin
        want = awaited_scores.pop_front();
        if (result.agree_both != want.agree_both)
          report_mismatch("agree_both", result.agree_both, want.agree_both);
        if (result.agree_first_only != want.agree_first_only)
          report_mismatch("agree_first_only", result.agree_first_only, want.agree_first_only);
        if (result.agree_second_only != want.agree_second_only)
          report_mismatch("agree_second_only", result.agree_second_only,
                          want.agree_second_only);
        if (result.agree_neither != want.agree_neither)
          report_mismatch("agree_neither", result.agree_neither, want.agree_neither);
        if (result.rand_fraction != want.rand_fraction)
          report_mismatch("rand_fraction", result.rand_fraction, want.rand_fraction);
        if (result.overflow != want.overflow)
          report_mismatch("overflow", result.overflow, want.overflow);
      end
    end
  end

  // Stop the run once nothing has moved for too long
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("FAIL rand_index_pair_counter_core");
    $finish;
  end

  initial begin
    ripc_pkg::in_item_t  b;
    ripc_pkg::out_item_t full_score;
    int unsigned         sent;
    int unsigned         set_len;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    clear_tallies();
    idle_pct = IDLE_PCT[0];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int r = 0; r < DIRECTED_LEN; r++)
      send_beat(DIRECTED_ROWS[r].beat, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

    // Fill to capacity with identical labels, then overflow; both beats beyond capacity are dropped
    b = '{first_label: 6'd63, second_label: 6'd63, is_last: 1'b0};
    for (int k = 0; k < CAPACITY; k++) send_beat(b, 1'b0, '0);
    send_beat('{first_label: 6'd0, second_label: 6'd0, is_last: 1'b0}, 1'b0, '0);
    full_score = '{agree_both: 21'd1048576, agree_first_only: 21'd0,
                   agree_second_only: 21'd0, agree_neither: 21'd0,
                   rand_fraction: 17'd65536, overflow: 1'b1};
    send_beat('{first_label: 6'd1, second_label: 6'd2, is_last: 1'b1}, 1'b1, full_score);

    // Random sets, one idle profile per phase; drain between phases
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = IDLE_PCT[p];
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(4) == 0) set_len = $urandom_range(64, 9);
        else set_len = $urandom_range(8, 1);
        send_random_set(set_len);
        sent += set_len;
      end
      drain_scores();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS rand_index_pair_counter_core");
    end else begin
      $display("FAIL rand_index_pair_counter_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
